@@ hdl/sorted_descending_insert_list_assert.svh @@
// Assertion macros for the sorted descending insert list.
// Used by the top level only; depends on nothing.
`ifndef SORTED_DESCENDING_INSERT_LIST_ASSERT_SVH
`define SORTED_DESCENDING_INSERT_LIST_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define SDIL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SDIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sdil_pkg.sv @@
// Shared types and constants for the sorted descending insert list.
// No dependencies.
package sdil_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int KEY_W  = 10;
    localparam int TAG_W  = 8;
    localparam int SEM_W  = 4;
    localparam int STAT_W = 2;
    localparam int DATA_W = 24;  // key, tag, semester padded to bytes

    // request kinds (tuser on the input side)
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    // result status codes (tuser on the output side)
    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ENTRY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [SEM_W-1:0] sem;
    } t_rec;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic rotate;
        t_rec rec;
    } t_chain_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

@@ hdl/sdil_cell.sv @@
// One storage cell of the sorted chain: holds a record, compares it with
// the incoming key and takes data from a neighbor. Uses sdil_pkg.
module sdil_cell import sdil_pkg::*; (
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  logic       i_occ,      // cell holds a live record
    input  logic       i_last,     // cell is the last live one
    input  logic       i_prev_gt,  // predecessor stays put on insert
    input  t_rec       i_prev,
    input  t_rec       i_next,
    input  t_rec       i_head,
    output logic       o_gt,
    output t_rec       o_rec
);

    t_rec r_rec;
    t_rec n_rec;

    assign o_gt  = i_occ && (r_rec.key > i_ctl.rec.key);
    assign o_rec = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.insert) begin
            if (!o_gt) begin
                n_rec = i_prev_gt ? i_ctl.rec : i_prev;
            end
        end else if (i_ctl.rotate) begin
            n_rec = i_last ? i_head : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

@@ hdl/sdil_chain.sv @@
// Row of DEPTH cells with neighbor links and per-cell occupancy decode.
// Uses sdil_pkg and sdil_cell.
module sdil_chain import sdil_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  t_chain_ctl    i_ctl,
    input  logic [CW-1:0] i_count,
    output t_rec          o_head
);

    t_rec w_rec [DEPTH];
    logic w_gt  [DEPTH];

    assign o_head = w_rec[0];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic w_prev_gt;
        t_rec w_prev;
        t_rec w_next;

        if (i == 0) begin : g_first
            assign w_prev_gt = 1'b1;
            assign w_prev    = i_ctl.rec;
        end else begin : g_mid
            assign w_prev_gt = w_gt[i-1];
            assign w_prev    = w_rec[i-1];
        end

        if (i == DEPTH - 1) begin : g_end
            assign w_next = w_rec[0];
        end else begin : g_inner
            assign w_next = w_rec[i+1];
        end

        sdil_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_occ     (IDX < i_count),
            .i_last    (IDX == (i_count - 1'b1)),
            .i_prev_gt (w_prev_gt),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .i_head    (w_rec[0]),
            .o_gt      (w_gt[i]),
            .o_rec     (w_rec[i])
        );
    end

endmodule

@@ hdl/sorted_descending_insert_list.sv @@
// Sorted descending insert list, top level. Uses sdil_pkg, sdil_chain.
// Insert: one beat per cycle when idle and not back-pressured; result in the
//   cycle after acceptance; all cells compare and shift in parallel. Dump
//   of n records: n beats, one per cycle unless back-pressured, all from the
//   DUMP state, which stalls input. Empty dump: one beat, like insert.
// Reset (i_rst_n low, synchronous) empties the list and the output register.
module sorted_descending_insert_list import sdil_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // key_credits[9:0], record_tag[17:10],
                                           // record_semester[21:18], zero pad
    input  logic              i_s_tuser,   // req_type
    // result side
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,   // out_key[9:0], out_tag[17:10],
                                           // out_semester[21:18], zero pad
    output logic [STAT_W-1:0] o_m_tuser,   // status
    output logic              o_m_tlast    // last_of_run
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;        // beats emitted in the current dump

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data,  n_out_data;
    logic [STAT_W-1:0] r_out_user,  n_out_user;
    logic              r_out_last,  n_out_last;

    t_chain_ctl w_ctl;
    t_rec       w_head;
    t_rec       w_in_rec;
    logic       w_load;       // output register free this cycle
    logic       w_accept;
    logic       w_dump_last;

    assign w_in_rec.key = i_s_tdata[KEY_W-1:0];
    assign w_in_rec.tag = i_s_tdata[KEY_W+TAG_W-1:KEY_W];
    assign w_in_rec.sem = i_s_tdata[KEY_W+TAG_W+SEM_W-1:KEY_W+TAG_W];

    // skid-free output register: refill when empty or drained this cycle
    assign w_load      = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == ST_IDLE) && w_load;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_dump_last = (r_idx == (r_count - 1'b1));

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_s_tuser == REQ_DUMP) && (r_count != '0)) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (w_load && w_dump_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs and datapath control ----------------
    always_comb begin
        w_ctl.insert = 1'b0;
        w_ctl.rotate = 1'b0;
        w_ctl.rec    = w_in_rec;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_out_last   = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_last  = 1'b1;
                    if (i_s_tuser == REQ_INSERT) begin
                        // full list: chain drops its tail (or the newcomer)
                        w_ctl.insert = 1'b1;
                        if (r_count == FULL) begin
                            n_out_user = STAT_DROPPED;
                        end else begin
                            n_out_user = STAT_INSERTED;
                            n_count    = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_out_user = STAT_EMPTY;
                    end else begin
                        // non-empty dump: beats come from the DUMP state
                        n_out_valid = 1'b0;
                    end
                end
            end
            ST_DUMP: begin
                if (w_load) begin
                    // emit head, rotate so the list is restored after n steps
                    w_ctl.rotate = 1'b1;
                    n_idx        = r_idx + 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_data   = DATA_W'({w_head.sem, w_head.tag, w_head.key});
                    n_out_user   = STAT_ENTRY;
                    n_out_last   = w_dump_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    sdil_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_count (r_count),
        .o_head  (w_head)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    // ---------------- assertions ----------------
`include "sorted_descending_insert_list_assert.svh"

    `SDIL_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL, "count above depth")
    `SDIL_ASSERT_NEXT(a_insert_result, i_clk, i_rst_n, w_accept && (i_s_tuser == REQ_INSERT), o_m_tvalid && o_m_tlast && (o_m_tuser == STAT_INSERTED || o_m_tuser == STAT_DROPPED), "insert gave no single result")
    `SDIL_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, w_accept && (i_s_tuser == REQ_INSERT) && (r_count != FULL), r_count == $past(r_count) + 1'b1, "count not bumped on insert")
    `SDIL_ASSERT_ALWAYS(a_dump_stall, i_clk, i_rst_n, (r_state != ST_DUMP) || !o_s_tready, "request taken during dump")

endmodule
